[hw/rtl/ldsce_pkg.sv]
// Shared types, codes and sizing constants for the laser DAC stream command engine.
`default_nettype none

package ldsce_pkg;

  // Frame buffer size in points and rate queue depth.
  localparam int unsigned BUFFER_POINTS   = 8192;
  localparam int unsigned RATE_FIFO_DEPTH = 8;

  localparam int FIFO_IDX_W = $clog2(RATE_FIFO_DEPTH);
  localparam int LEVEL_W    = $clog2(BUFFER_POINTS + 1);

  // Field widths fixed by the interface.
  localparam int OP_W     = 4;
  localparam int RATE_IN_W = 32;
  localparam int RATE_W   = 20;
  localparam int COUNT_W  = 16;
  localparam int BLEVEL_W = 14;
  localparam int COLOR_W  = 16;
  localparam int TOTAL_W  = 32;
  localparam int FULL_W   = 11;
  localparam int FIT_W    = 18;

  // Fullness is reported on a 0..1799 scale.
  localparam logic [FULL_W-1:0] FULL_SCALE = 11'd1799;

  typedef enum logic [OP_W-1:0] {
    OP_PREPARE     = 4'd0,
    OP_BEGIN       = 4'd1,
    OP_QUEUE_RATE  = 4'd2,
    OP_DATA        = 4'd3,
    OP_POINT       = 4'd4,
    OP_STOP        = 4'd5,
    OP_ESTOP       = 4'd6,
    OP_CLEAR_ESTOP = 4'd7,
    OP_PING        = 4'd8,
    OP_CONNECT     = 4'd9,
    OP_DISCONNECT  = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_FULL  = 2'd2,
    KIND_INVAL = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PS_IDLE     = 2'd0,
    PS_PREPARED = 2'd1,
    PS_PLAYING  = 2'd2
  } play_t;

  typedef enum logic [1:0] {
    ES_READY = 2'd0,
    ES_STOP  = 2'd3
  } engine_t;

  // Command bytes echoed in a response.
  localparam logic [7:0] ECHO_NONE    = 8'h00;
  localparam logic [7:0] ECHO_ESTOP   = 8'h00;
  localparam logic [7:0] ECHO_PREPARE = 8'h70;  // 'p'
  localparam logic [7:0] ECHO_BEGIN   = 8'h62;  // 'b'
  localparam logic [7:0] ECHO_QUEUE   = 8'h71;  // 'q'
  localparam logic [7:0] ECHO_DATA    = 8'h64;  // 'd'
  localparam logic [7:0] ECHO_STOP    = 8'h73;  // 's'
  localparam logic [7:0] ECHO_CLEAR   = 8'h63;  // 'c'
  localparam logic [7:0] ECHO_PING    = 8'h3F;  // '?'

  localparam logic [2:0] PFLAG_PLAYING = 3'b001;
  localparam logic [2:0] PFLAG_ESTOP   = 3'b100;

  localparam logic CFG_MIN_RATE = 1'b0;
  localparam logic CFG_MAX_RATE = 1'b1;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         echo;
    play_t              play;
    engine_t            engine;
    logic               eflags;
    logic [2:0]         pflags;
    logic [FULL_W-1:0]  fullness;
    logic [RATE_W-1:0]  rate;
    logic [TOTAL_W-1:0] total;
    logic               blank;
    logic [RATE_W-1:0]  update;
    logic               clear;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/laser_dac_stream_command_engine.sv]
// Laser DAC stream command engine: playback state, e-stop, rate queue and responses.
// Results are registered in the result register, or in the skid register on a stall.
// Throughput: one item per cycle while in_stall is low; a two-entry output stage
// (result plus skid register) keeps the input open for one more item while stalled.
// Reset (rst, synchronous, active high) returns to idle, ready, zero rate and count,
// an empty rate queue and min/max rates of 1 and 100000 points per second.
`default_nettype none

module laser_dac_stream_command_engine
  import ldsce_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,

  // Configuration write port.
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [RATE_W-1:0]    cfg_data,

  // Input channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      operation,
  input  wire logic [RATE_IN_W-1:0] rate_value,
  input  wire logic [COUNT_W-1:0]   points_announced,
  input  wire logic [BLEVEL_W-1:0]  buffer_level,
  input  wire logic                 rate_change_bit,
  input  wire logic [COLOR_W-1:0]   red,
  input  wire logic [COLOR_W-1:0]   green,
  input  wire logic [COLOR_W-1:0]   blue,

  // Output channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                response_kind,
  output logic [7:0]                command_echo,
  output logic [1:0]                stream_state,
  output logic [1:0]                engine_state,
  output logic                      engine_flags,
  output logic [2:0]                stream_flags,
  output logic [FULL_W-1:0]         fill_report,
  output logic [RATE_W-1:0]         reported_rate,
  output logic [TOTAL_W-1:0]        points_total,
  output logic                      point_blank,
  output logic [RATE_W-1:0]         scan_rate_update,
  output logic                      clear_buffer
);

  // Configuration registers.
  logic [RATE_W-1:0] min_rate;
  logic [RATE_W-1:0] max_rate;

  // Engine state.
  play_t                play_state, play_state_next;
  engine_t              engine_stop, engine_stop_next;
  logic                 engine_flag, engine_flag_next;
  logic [2:0]           play_flags, play_flags_next;
  logic [RATE_W-1:0]    current_rate, current_rate_next;
  logic [TOTAL_W-1:0]   accepted_points, accepted_points_next;
  logic [COUNT_W-1:0]   points_remaining, points_remaining_next;
  logic [FIFO_IDX_W-1:0] fifo_wr, fifo_wr_next;
  logic [FIFO_IDX_W-1:0] fifo_rd, fifo_rd_next;

  // Rate queue storage. Entries are always written before they are read, so the
  // array has no reset.
  logic [RATE_IN_W-1:0] rate_fifo [RATE_FIFO_DEPTH];
  logic                 fifo_we;

  // Output stage: result register and skid register.
  result_t res;
  result_t out_q;
  result_t skid_q;
  logic    skid_valid;
  logic    in_acc;
  logic    out_take;
  logic    out_load;
  logic    skid_load;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  // The result register loads a new item when it is empty or being drained and the
  // skid register has nothing older. Otherwise a new item parks in the skid register.
  assign out_load  = in_acc && (!out_valid || (out_take && !skid_valid));
  assign skid_load = in_acc && out_valid && out_stall;

  // Helper values computed from the input item.
  logic [FIFO_IDX_W-1:0] wr_inc, rd_inc;
  logic                  fifo_empty, fifo_full;
  logic [RATE_IN_W-1:0]  popped;
  logic [RATE_IN_W-1:0]  min_ext, max_ext;
  logic [RATE_IN_W-1:0]  clamp_lo, clamp_rate;
  logic                  popped_ok;
  logic                  fits;
  logic                  is_blank;
  logic [COUNT_W-1:0]    remaining_dec;

  assign wr_inc = (fifo_wr == FIFO_IDX_W'(RATE_FIFO_DEPTH - 1)) ? '0 : fifo_wr + 1'b1;
  assign rd_inc = (fifo_rd == FIFO_IDX_W'(RATE_FIFO_DEPTH - 1)) ? '0 : fifo_rd + 1'b1;
  assign fifo_empty = (fifo_wr == fifo_rd);
  assign fifo_full  = (wr_inc == fifo_rd);
  assign popped     = rate_fifo[fifo_rd];

  assign min_ext = RATE_IN_W'(min_rate);
  assign max_ext = RATE_IN_W'(max_rate);

  // Begin: raise to the minimum first, then lower to the maximum, so the maximum wins
  // if the two registers are crossed.
  assign clamp_lo   = (rate_value < min_ext) ? min_ext : rate_value;
  assign clamp_rate = (clamp_lo > max_ext) ? max_ext : clamp_lo;
  assign popped_ok  = (popped >= min_ext) && (popped <= max_ext);

  assign fits = (FIT_W'(buffer_level) + FIT_W'(points_announced)) <= FIT_W'(BUFFER_POINTS);
  assign is_blank = (red == '0) && (green == '0) && (blue == '0);
  assign remaining_dec = points_remaining - 1'b1;

  // Buffer fullness: saturate the level to the buffer size, then scale to 0..1799.
  localparam int PROD_W = LEVEL_W + FULL_W;
  logic [LEVEL_W-1:0] level_sat;
  logic [PROD_W-1:0]  full_prod;
  logic [FULL_W-1:0]  full_scaled;

  assign level_sat = (32'(buffer_level) > 32'(BUFFER_POINTS)) ?
                     LEVEL_W'(BUFFER_POINTS) : LEVEL_W'(buffer_level);
  assign full_prod   = PROD_W'(level_sat) * PROD_W'(FULL_SCALE);
  assign full_scaled = FULL_W'(full_prod / BUFFER_POINTS);

  // Next state and response for the presented item.
  kind_t             kind;
  logic [7:0]        echo;
  logic              pblank;
  logic [RATE_W-1:0] upd;
  logic              clr;

  always_comb begin
    play_state_next       = play_state;
    engine_stop_next      = engine_stop;
    engine_flag_next      = engine_flag;
    play_flags_next       = play_flags;
    current_rate_next     = current_rate;
    accepted_points_next  = accepted_points;
    points_remaining_next = points_remaining;
    fifo_wr_next          = fifo_wr;
    fifo_rd_next          = fifo_rd;
    fifo_we               = 1'b0;
    kind                  = KIND_NONE;
    echo                  = ECHO_NONE;
    pblank                = 1'b0;
    upd                   = '0;
    clr                   = 1'b0;

    unique case (operation)
      OP_PREPARE: begin
        echo = ECHO_PREPARE;
        if (engine_stop != ES_READY || play_state != PS_IDLE) begin
          kind = KIND_INVAL;
        end else begin
          clr                  = 1'b1;
          fifo_wr_next         = '0;
          fifo_rd_next         = '0;
          accepted_points_next = '0;
          play_state_next      = PS_PREPARED;
          kind                 = KIND_ACK;
        end
      end
      OP_BEGIN: begin
        echo = ECHO_BEGIN;
        if (play_state != PS_PREPARED || buffer_level == '0) begin
          kind = KIND_INVAL;
        end else begin
          current_rate_next = clamp_rate[RATE_W-1:0];
          play_state_next   = PS_PLAYING;
          play_flags_next   = play_flags | PFLAG_PLAYING;
          upd               = clamp_rate[RATE_W-1:0];
          kind              = KIND_ACK;
        end
      end
      OP_QUEUE_RATE: begin
        echo = ECHO_QUEUE;
        if (play_state != PS_PREPARED && play_state != PS_PLAYING) begin
          kind = KIND_INVAL;
        end else begin
          // A full queue drops the rate but still acknowledges.
          if (!fifo_full) begin
            fifo_we      = 1'b1;
            fifo_wr_next = wr_inc;
          end
          kind = KIND_ACK;
        end
      end
      OP_DATA: begin
        if (!fits) begin
          points_remaining_next = '0;
          echo                  = ECHO_DATA;
          kind                  = KIND_FULL;
        end else if (points_announced == '0) begin
          points_remaining_next = '0;
          echo                  = ECHO_DATA;
          kind                  = KIND_ACK;
        end else begin
          points_remaining_next = points_announced;
        end
      end
      OP_POINT: begin
        // Points with no data header pending are ignored.
        if (points_remaining != '0) begin
          pblank = is_blank;
          if (rate_change_bit && !fifo_empty) begin
            fifo_rd_next = rd_inc;
            if (popped_ok) begin
              current_rate_next = popped[RATE_W-1:0];
              upd               = popped[RATE_W-1:0];
            end
          end
          accepted_points_next  = accepted_points + 1'b1;
          points_remaining_next = remaining_dec;
          if (remaining_dec == '0) begin
            echo = ECHO_DATA;
            kind = KIND_ACK;
          end
        end
      end
      OP_STOP: begin
        play_state_next   = PS_IDLE;
        play_flags_next   = play_flags & ~PFLAG_PLAYING;
        current_rate_next = '0;
        echo              = ECHO_STOP;
        kind              = KIND_ACK;
      end
      OP_ESTOP: begin
        engine_stop_next  = ES_STOP;
        engine_flag_next  = 1'b1;
        play_state_next   = PS_IDLE;
        play_flags_next   = PFLAG_ESTOP;
        current_rate_next = '0;
        clr               = 1'b1;
        echo              = ECHO_ESTOP;
        kind              = KIND_ACK;
      end
      OP_CLEAR_ESTOP: begin
        echo = ECHO_CLEAR;
        if (engine_stop != ES_STOP) begin
          kind = KIND_INVAL;
        end else begin
          engine_stop_next = ES_READY;
          engine_flag_next = 1'b0;
          play_state_next  = PS_IDLE;
          kind             = KIND_ACK;
        end
      end
      OP_PING: begin
        echo = ECHO_PING;
        kind = KIND_ACK;
      end
      OP_CONNECT: begin
        play_state_next       = PS_IDLE;
        clr                   = 1'b1;
        fifo_wr_next          = '0;
        fifo_rd_next          = '0;
        accepted_points_next  = '0;
        points_remaining_next = '0;
        echo                  = ECHO_PING;
        kind                  = KIND_ACK;
      end
      OP_DISCONNECT: begin
        play_state_next       = PS_IDLE;
        current_rate_next     = '0;
        points_remaining_next = '0;
      end
      default: begin
        // Unknown operation codes leave everything unchanged and give no response.
      end
    endcase
  end

  // Result snapshot taken from the state after the item.
  always_comb begin
    res.kind     = kind;
    res.echo     = echo;
    res.play     = play_state_next;
    res.engine   = engine_stop_next;
    res.eflags   = engine_flag_next;
    res.pflags   = play_flags_next;
    res.fullness = clr ? '0 : full_scaled;
    res.rate     = (play_state_next == PS_PLAYING) ? current_rate_next : '0;
    res.total    = accepted_points_next;
    res.blank    = pblank;
    res.update   = upd;
    res.clear    = clr;
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_rate         <= RATE_W'(1);
      max_rate         <= RATE_W'(100000);
      play_state       <= PS_IDLE;
      engine_stop      <= ES_READY;
      engine_flag      <= 1'b0;
      play_flags       <= '0;
      current_rate     <= '0;
      accepted_points  <= '0;
      points_remaining <= '0;
      fifo_wr          <= '0;
      fifo_rd          <= '0;
      out_valid        <= 1'b0;
      skid_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_MIN_RATE) begin
          min_rate <= cfg_data;
        end else begin
          max_rate <= cfg_data;
        end
      end
      if (in_acc) begin
        play_state       <= play_state_next;
        engine_stop      <= engine_stop_next;
        engine_flag      <= engine_flag_next;
        play_flags       <= play_flags_next;
        current_rate     <= current_rate_next;
        accepted_points  <= accepted_points_next;
        points_remaining <= points_remaining_next;
        fifo_wr          <= fifo_wr_next;
        fifo_rd          <= fifo_rd_next;
      end
      // Output stage occupancy.
      if (out_take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!in_acc) begin
          out_valid <= 1'b0;
        end
      end else if (!out_valid) begin
        if (in_acc) begin
          out_valid <= 1'b1;
        end
      end else if (skid_load) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload registers and queue storage.
  always_ff @(posedge clk) begin
    if (fifo_we && in_acc) begin
      rate_fifo[fifo_wr] <= rate_value;
    end
    if (out_take && skid_valid) begin
      out_q <= skid_q;
    end else if (out_load) begin
      out_q <= res;
    end
    if (skid_load) begin
      skid_q <= res;
    end
  end

  assign response_kind    = out_q.kind;
  assign command_echo     = out_q.echo;
  assign stream_state     = out_q.play;
  assign engine_state     = out_q.engine;
  assign engine_flags     = out_q.eflags;
  assign stream_flags     = out_q.pflags;
  assign fill_report      = out_q.fullness;
  assign reported_rate    = out_q.rate;
  assign points_total     = out_q.total;
  assign point_blank      = out_q.blank;
  assign scan_rate_update = out_q.update;
  assign clear_buffer     = out_q.clear;

endmodule

`default_nettype wire

[hw/rtl/ldsce_checker.sv]
// Port-level checker for the laser DAC stream command engine, with its bind.
`default_nettype none

module ldsce_checker
  import ldsce_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [1:0]        response_kind,
  input wire logic [7:0]        command_echo,
  input wire logic [1:0]        stream_state,
  input wire logic [1:0]        engine_state,
  input wire logic              engine_flags,
  input wire logic [FULL_W-1:0] fill_report,
  input wire logic [RATE_W-1:0] reported_rate,
  input wire logic              clear_buffer
);

  // A stalled result stays on the port.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(response_kind) && $stable(command_echo))
    else $error("stalled result was not held");

  // Items that get no response carry no command byte.
  a_none_no_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && response_kind == KIND_NONE |-> command_echo == ECHO_NONE)
    else $error("response none with a command byte");

  // A buffer clear always reports an empty buffer.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && clear_buffer |-> fill_report == '0)
    else $error("fullness reported with buffer clear");

  // Rate is only reported while playing.
  a_rate_playing: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_state != PS_PLAYING |-> reported_rate == '0)
    else $error("rate reported while not playing");

  // The emergency-stop flag and the engine state move together.
  a_estop_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> engine_flags == (engine_state == ES_STOP))
    else $error("estop flag and engine state disagree");

endmodule

bind laser_dac_stream_command_engine ldsce_checker u_ldsce_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .response_kind   (response_kind),
  .command_echo    (command_echo),
  .stream_state    (stream_state),
  .engine_state    (engine_state),
  .engine_flags    (engine_flags),
  .fill_report     (fill_report),
  .reported_rate   (reported_rate),
  .clear_buffer    (clear_buffer)
);

`default_nettype wire
